// ===== rtl/irtx_pkg.sv =====
// irtx_pkg: shared types and constants for the IR remote pulse transmitter.
// No dependencies; used by irtx_fsm and ir_remote_pulse_transmitter.

package irtx_pkg;

    // Default parameter values
    localparam int CODE_WIDTH_DEF  = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int TX_CODE_W   = 16;
    localparam int TICKS_W     = 16;
    localparam int BITS_W      = 5;
    localparam int FRAMES_W    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_TICKS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPACE_TICKS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_TICKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAP_TICKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BITS_FRAME   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FRAMES_CMD   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS = 3'd6;

    // Register reset values
    localparam logic [TICKS_W-1:0]  HEADER_TICKS_RST = 16'd96;
    localparam logic [TICKS_W-1:0]  SPACE_TICKS_RST  = 16'd24;
    localparam logic [TICKS_W-1:0]  ONE_TICKS_RST    = 16'd48;
    localparam logic [TICKS_W-1:0]  GAP_TICKS_RST    = 16'd1800;
    localparam logic [BITS_W-1:0]   BITS_FRAME_RST   = 5'd16;
    localparam logic [FRAMES_W-1:0] FRAMES_CMD_RST   = 4'd10;
    localparam logic [TICKS_W-1:0]  SETTLE_TICKS_RST = 16'd40000;

    // Input kind (carried on s_tuser)
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    typedef struct packed {
        logic [TICKS_W-1:0]  header_ticks;
        logic [TICKS_W-1:0]  space_ticks;
        logic [TICKS_W-1:0]  one_ticks;
        logic [TICKS_W-1:0]  gap_ticks;
        logic [BITS_W-1:0]   bits_per_frame;
        logic [FRAMES_W-1:0] frames_per_command;
        logic [TICKS_W-1:0]  settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic command_done;
        logic start_accepted;
        logic busy_res;
        logic carrier_on;
    } res_t;

endpackage

// ===== rtl/irtx_fsm.sv =====
// irtx_fsm: frame sequencer. Holds phase, tick counter, shift word and
// bit/frame counts; computes one result per step. Depends on irtx_pkg.

module irtx_fsm #(
    parameter int CODE_WIDTH  = irtx_pkg::CODE_WIDTH_DEF,
    parameter int COUNT_WIDTH = irtx_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              step_en,
    input  logic                              func,
    input  logic [irtx_pkg::TX_CODE_W-1:0]    tx_code,
    input  irtx_pkg::cfg_t                    cfg,
    output irtx_pkg::res_t                    res
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_SPACE  = 3'd2;
    localparam logic [2:0] PH_BURST  = 3'd3;
    localparam logic [2:0] PH_GAP    = 3'd4;
    localparam logic [2:0] PH_SETTLE = 3'd5;

    localparam logic [COUNT_WIDTH-1:0] TICK_ONE = COUNT_WIDTH'(1);

    logic [2:0]                   phase_reg,  phase_next;
    logic [COUNT_WIDTH-1:0]       ticks_reg,  ticks_next;
    logic [CODE_WIDTH-1:0]        shift_reg,  shift_next;
    logic [irtx_pkg::BITS_W-1:0]  bits_reg,   bits_next;
    logic [irtx_pkg::FRAMES_W-1:0] frames_reg, frames_next;
    logic [CODE_WIDTH-1:0]        held_reg,   held_next;

    logic [irtx_pkg::FRAMES_W-1:0] frames_dec;
    logic [COUNT_WIDTH-1:0]        settle_c;

    // Duration register truncated to the counter width; zero counts as one.
    function automatic logic [COUNT_WIDTH-1:0] at_least_one(
        input logic [irtx_pkg::TICKS_W-1:0] v
    );
        logic [COUNT_WIDTH-1:0] d;
        d = COUNT_WIDTH'(v);
        return (d == '0) ? TICK_ONE : d;
    endfunction

    assign frames_dec = frames_reg - irtx_pkg::FRAMES_W'(1);
    assign settle_c   = COUNT_WIDTH'(cfg.settle_ticks);

    always_comb begin
        phase_next  = phase_reg;
        ticks_next  = ticks_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        frames_next = frames_reg;
        held_next   = held_reg;
        res         = '0;

        if (step_en) begin
            if (func == irtx_pkg::FUNC_START) begin
                if (phase_reg == PH_IDLE) begin
                    held_next   = CODE_WIDTH'(tx_code);
                    frames_next = (cfg.frames_per_command == '0) ?
                                  irtx_pkg::FRAMES_W'(1) : cfg.frames_per_command;
                    shift_next  = CODE_WIDTH'(tx_code);
                    bits_next   = (cfg.bits_per_frame == '0) ?
                                  irtx_pkg::BITS_W'(1) : cfg.bits_per_frame;
                    phase_next  = PH_HEADER;
                    ticks_next  = at_least_one(cfg.header_ticks);
                    res.start_accepted = 1'b1;
                end
            end else if (phase_reg != PH_IDLE) begin
                res.carrier_on = (phase_reg == PH_HEADER) || (phase_reg == PH_BURST);
                if (ticks_reg != TICK_ONE) begin
                    ticks_next = ticks_reg - TICK_ONE;
                end else begin
                    // phase runs out on this tick
                    unique case (phase_reg)
                        PH_HEADER: begin
                            phase_next = PH_SPACE;
                            ticks_next = at_least_one(cfg.space_ticks);
                        end
                        PH_SPACE: begin
                            phase_next = PH_BURST;
                            ticks_next = shift_reg[0] ? at_least_one(cfg.one_ticks)
                                                      : at_least_one(cfg.space_ticks);
                            shift_next = shift_reg >> 1;
                            bits_next  = bits_reg - irtx_pkg::BITS_W'(1);
                        end
                        PH_BURST: begin
                            if (bits_reg == '0) begin
                                phase_next = PH_GAP;
                                ticks_next = at_least_one(cfg.gap_ticks);
                            end else begin
                                phase_next = PH_SPACE;
                                ticks_next = at_least_one(cfg.space_ticks);
                            end
                        end
                        PH_GAP: begin
                            frames_next = frames_dec;
                            if (frames_dec != '0) begin
                                // repeat frame from the held code
                                shift_next = held_reg;
                                bits_next  = (cfg.bits_per_frame == '0) ?
                                             irtx_pkg::BITS_W'(1) : cfg.bits_per_frame;
                                phase_next = PH_HEADER;
                                ticks_next = at_least_one(cfg.header_ticks);
                            end else if (settle_c == '0) begin
                                phase_next = PH_IDLE;
                                ticks_next = '0;
                                res.command_done = 1'b1;
                            end else begin
                                phase_next = PH_SETTLE;
                                ticks_next = settle_c;
                            end
                        end
                        PH_SETTLE: begin
                            phase_next = PH_IDLE;
                            ticks_next = '0;
                            res.command_done = 1'b1;
                        end
                        default: begin
                            phase_next = PH_IDLE;
                            ticks_next = '0;
                        end
                    endcase
                end
            end
            res.busy_res = (phase_next != PH_IDLE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            ticks_reg  <= '0;
            bits_reg   <= '0;
            frames_reg <= '0;
            shift_reg  <= '0;
            held_reg   <= '0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            ticks_reg  <= ticks_next;
            bits_reg   <= bits_next;
            frames_reg <= frames_next;
            shift_reg  <= shift_next;
            held_reg   <= held_next;
        end
    end

    // A running phase never has an empty tick counter.
    a_ticks_live: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != PH_IDLE |-> ticks_reg != '0)
        else $error("irtx_fsm: active phase with zero tick count");

    // Starts are only taken from idle.
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.start_accepted |-> phase_reg == PH_IDLE && step_en)
        else $error("irtx_fsm: start taken while busy");

    // Done always returns the sequencer to idle.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        res.command_done && step_en |=> phase_reg == PH_IDLE)
        else $error("irtx_fsm: done without return to idle");

    // Carrier is only gated on tick items.
    a_carrier_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        res.carrier_on |-> step_en && func == irtx_pkg::FUNC_TICK)
        else $error("irtx_fsm: carrier on outside a tick");

endmodule

// ===== rtl/ir_remote_pulse_transmitter.sv =====
// ir_remote_pulse_transmitter: top level. Config registers, input stream,
// frame sequencer (irtx_fsm) and registered output stage. Uses irtx_pkg.
//
// Channel   Dir  Signals                      Payload
// s_        in   s_tvalid/s_tready/s_tdata    tdata[15:0] tx_code, tuser func
//                s_tuser
// m_        out  m_tvalid/m_tready/m_tdata    tdata[3:0] carrier_on, busy_res,
//                                             start_accepted, command_done
// cfg_      in   cfg_wr_en/index/data         register write, no handshake
//
// One transfer per cycle in both directions while the output is not stalled: the
// sequencer step is a single pass of combinational logic, so each item's result
// sits in the output register in the cycle after its input transfer.
// Stalls: s_tready drops only while the output register is full and
// m_tready is low; the sequencer state advances only on an input transfer.
// Reset (aresetn, synchronous, active low): sequencer idle, output empty,
// registers at their defaults. No clearing pass; s_tready is high from the
// first cycle out of reset.

module ir_remote_pulse_transmitter #(
    parameter int CODE_WIDTH  = irtx_pkg::CODE_WIDTH_DEF,
    parameter int COUNT_WIDTH = irtx_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    // config write port
    input  logic                              cfg_wr_en,
    input  logic [irtx_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [irtx_pkg::CFG_DATA_W-1:0]   cfg_wr_data,

    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [irtx_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] tx_code
    input  logic                              s_tuser,   // [0] func (1 = start)

    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [irtx_pkg::M_TDATA_W-1:0]    m_tdata    // [0] carrier_on,
                                                         // [1] busy_res,
                                                         // [2] start_accepted,
                                                         // [3] command_done,
                                                         // [7:4] zero
);

    irtx_pkg::cfg_t cfg_reg;
    irtx_pkg::res_t res;
    irtx_pkg::res_t res_reg;
    logic           m_valid_reg;
    logic           in_xfer;

    // ---------------- configuration registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.header_ticks       <= irtx_pkg::HEADER_TICKS_RST;
            cfg_reg.space_ticks        <= irtx_pkg::SPACE_TICKS_RST;
            cfg_reg.one_ticks          <= irtx_pkg::ONE_TICKS_RST;
            cfg_reg.gap_ticks          <= irtx_pkg::GAP_TICKS_RST;
            cfg_reg.bits_per_frame     <= irtx_pkg::BITS_FRAME_RST;
            cfg_reg.frames_per_command <= irtx_pkg::FRAMES_CMD_RST;
            cfg_reg.settle_ticks       <= irtx_pkg::SETTLE_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                irtx_pkg::REG_HEADER_TICKS: cfg_reg.header_ticks <= cfg_wr_data;
                irtx_pkg::REG_SPACE_TICKS:  cfg_reg.space_ticks  <= cfg_wr_data;
                irtx_pkg::REG_ONE_TICKS:    cfg_reg.one_ticks    <= cfg_wr_data;
                irtx_pkg::REG_GAP_TICKS:    cfg_reg.gap_ticks    <= cfg_wr_data;
                irtx_pkg::REG_BITS_FRAME:
                    cfg_reg.bits_per_frame <= cfg_wr_data[irtx_pkg::BITS_W-1:0];
                irtx_pkg::REG_FRAMES_CMD:
                    cfg_reg.frames_per_command <= cfg_wr_data[irtx_pkg::FRAMES_W-1:0];
                irtx_pkg::REG_SETTLE_TICKS: cfg_reg.settle_ticks <= cfg_wr_data;
                default: ;  // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- input handshake ----------------
    // Take a new item whenever the output slot is free or being drained.
    assign s_tready = !m_valid_reg || m_tready;
    assign in_xfer  = s_tvalid && s_tready;

    irtx_fsm #(
        .CODE_WIDTH  (CODE_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (in_xfer),
        .func    (s_tuser),
        .tx_code (s_tdata),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, res_reg.command_done, res_reg.start_accepted,
                       res_reg.busy_res, res_reg.carrier_on};

    // Every input transfer yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> m_valid_reg)
        else $error("irtx: input transfer without result");

    // An empty output stage never back-pressures the input.
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_tready)
        else $error("irtx: input stalled with empty output");

    // A held result is not overwritten by a new item.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_tready |-> !in_xfer)
        else $error("irtx: result overwritten while stalled");

endmodule

// ===== dv/ir_remote_pulse_transmitter_tb.sv =====
// Self-checking testbench for ir_remote_pulse_transmitter: drives tick/start transfers,
// predicts every carrier/busy/accept/done result in-line and compares at the m_ side.
// Depends on rtl/irtx_pkg.sv, rtl/irtx_fsm.sv and rtl/ir_remote_pulse_transmitter.sv.
`timescale 1ns / 100ps

module ir_remote_pulse_transmitter_tb;
    import irtx_pkg::*;

    // About 1200 transfers under the heaviest idling; leave a wide margin.
    localparam int CYCLE_LIMIT = 200_000;

    typedef enum logic [2:0] {
        P_IDLE, P_HEADER, P_SPACE, P_BURST, P_GAP, P_SETTLE
    } tx_phase_e;

    // directed row: input kind, code word, result typed in by hand
    typedef struct packed {
        logic                 fn;
        logic [TX_CODE_W-1:0] code;
        res_t                 want;
    } dir_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;     // [15:0] tx_code
    logic                  s_tuser = 1'b0;   // [0] func (1 = start)
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [0] carrier_on, [1] busy_res,
                                             // [2] start_accepted, [3] command_done

    // typed result riding along with the current s_ transfer (directed rows)
    logic row_typed = 1'b0;
    res_t row_want = '0;

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int fails = 0;
    int cyc = 0;
    int busy_items = 0;   // transfers the block acted on (accepted starts, busy ticks)

    res_t pending_levels[$];

    // ---------------- predictor state ----------------
    cfg_t                 cfg;
    tx_phase_e            ph = P_IDLE;
    logic [TICKS_W-1:0]   tleft = '0;
    logic [TX_CODE_W-1:0] shreg = '0;
    logic [BITS_W-1:0]    bleft = '0;
    logic [FRAMES_W-1:0]  fleft = '0;
    logic [TX_CODE_W-1:0] code_q = '0;

    dir_row_t dir_rows [8];

    ir_remote_pulse_transmitter DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    always #5 aclk = ~aclk;

    // ---------------- pulse sequencer model ----------------
    // A programmed duration of zero still lasts one tick.
    function automatic logic [TICKS_W-1:0] at_least_one(input logic [TICKS_W-1:0] v);
        return (v == '0) ? TICKS_W'(1) : v;
    endfunction

    function automatic void load_frame();
        shreg = code_q;
        bleft = (cfg.bits_per_frame == '0) ? BITS_W'(1) : cfg.bits_per_frame;
        ph    = P_HEADER;
        tleft = at_least_one(cfg.header_ticks);
    endfunction

    // current phase ran out; move on, return 1 when the command finishes
    function automatic logic phase_over();
        logic fin;
        fin = 1'b0;
        case (ph)
            P_HEADER: begin
                ph    = P_SPACE;
                tleft = at_least_one(cfg.space_ticks);
            end
            P_SPACE: begin
                // bits past the code word shift in as zeros -> short bursts
                ph    = P_BURST;
                tleft = shreg[0] ? at_least_one(cfg.one_ticks)
                                 : at_least_one(cfg.space_ticks);
                shreg = shreg >> 1;
                bleft = bleft - 1'b1;
            end
            P_BURST: begin
                if (bleft == '0) begin
                    ph    = P_GAP;
                    tleft = at_least_one(cfg.gap_ticks);
                end else begin
                    ph    = P_SPACE;
                    tleft = at_least_one(cfg.space_ticks);
                end
            end
            P_GAP: begin
                fleft = fleft - 1'b1;
                if (fleft != '0) begin
                    load_frame();
                end else if (cfg.settle_ticks == '0) begin
                    // no settle wait: done on the gap's last tick
                    ph    = P_IDLE;
                    tleft = '0;
                    fin   = 1'b1;
                end else begin
                    ph    = P_SETTLE;
                    tleft = cfg.settle_ticks;
                end
            end
            P_SETTLE: begin
                ph    = P_IDLE;
                tleft = '0;
                fin   = 1'b1;
            end
            default: begin
                ph    = P_IDLE;
                tleft = '0;
            end
        endcase
        return fin;
    endfunction

    function automatic res_t next_levels(input logic fn, input logic [TX_CODE_W-1:0] code);
        res_t r;
        r = '0;
        if (fn == FUNC_START) begin
            // a start while busy is dropped without touching the state
            if (ph == P_IDLE) begin
                code_q = code;
                fleft  = (cfg.frames_per_command == '0) ? FRAMES_W'(1)
                                                        : cfg.frames_per_command;
                load_frame();
                r.start_accepted = 1'b1;
                busy_items++;
            end
        end else if (ph != P_IDLE) begin
            r.carrier_on = (ph == P_HEADER || ph == P_BURST);
            tleft = tleft - 1'b1;
            if (tleft == '0)
                r.command_done = phase_over();
            busy_items++;
        end
        r.busy_res = (ph != P_IDLE);
        return r;
    endfunction

    function automatic cfg_t make_cfg(input int h, input int sp, input int o, input int g,
                                      input int b, input int f, input int st);
        cfg_t c;
        c.header_ticks       = TICKS_W'(h);
        c.space_ticks        = TICKS_W'(sp);
        c.one_ticks          = TICKS_W'(o);
        c.gap_ticks          = TICKS_W'(g);
        c.bits_per_frame     = BITS_W'(b);
        c.frames_per_command = FRAMES_W'(f);
        c.settle_ticks       = TICKS_W'(st);
        return c;
    endfunction

    // short durations so commands finish quickly; bit counts mostly small,
    // sometimes beyond the code word
    function automatic cfg_t rand_cfg();
        int b;
        b = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(1, 8);
        return make_cfg($urandom_range(4), $urandom_range(4), $urandom_range(4),
                        $urandom_range(4), b, $urandom_range(3), $urandom_range(6));
    endfunction

    function automatic logic [TX_CODE_W-1:0] pick_code();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return TX_CODE_W'($urandom);
        endcase
    endfunction

    // ---------------- checking ----------------
    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s expected %0b got %0b", $time, name, want, got);
            fails++;
        end
    endtask

    // Output transfer is checked first, then the input transfer of the same
    // edge is predicted; both read pre-edge values.
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = res_t'(m_tdata[3:0]);
                if (pending_levels.size() == 0) begin
                    $display("%0t: unexpected result transfer expected none got %b",
                             $time, m_tdata);
                    fails++;
                end else begin
                    want = pending_levels.pop_front();
                    check_bit("carrier_on", want.carrier_on, got.carrier_on);
                    check_bit("busy_res", want.busy_res, got.busy_res);
                    check_bit("start_accepted", want.start_accepted, got.start_accepted);
                    check_bit("command_done", want.command_done, got.command_done);
                    if (m_tdata[M_TDATA_W-1:4] !== '0) begin
                        $display("%0t: m_tdata pad expected 0 got %b", $time,
                                 m_tdata[M_TDATA_W-1:4]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                want = next_levels(s_tuser, s_tdata);
                pending_levels.push_back(row_typed ? row_want : want);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side backpressure
    always @(negedge aclk)
        m_tready = (snk_idle_pct == 0) || ($urandom_range(99) >= snk_idle_pct);

    // ---------------- stimulus ----------------
    // Enters and leaves just after a falling edge; tvalid stays high after the
    // transfer so back-to-back items need no reassertion.
    task automatic send(input logic fn, input logic [TX_CODE_W-1:0] code,
                        input logic typed, input res_t want);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid  = 1'b1;
        s_tuser   = fn;
        s_tdata   = code;
        row_typed = typed;
        row_want  = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic tick();
        send(FUNC_TICK, TX_CODE_W'($urandom), 1'b0, '0);
    endtask

    // tick until the model is idle again
    task automatic run_to_idle();
        while (ph != P_IDLE)
            tick();
    endtask

    // stop sending and wait for every outstanding result
    task automatic quiesce();
        s_tvalid  = 1'b0;
        row_typed = 1'b0;
        while (pending_levels.size() != 0)
            @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en    = 1'b1;
        cfg_wr_index = idx;
        cfg_wr_data  = d;
        @(negedge aclk);
    endtask

    // only called with no transfer in flight
    task automatic load_regs(input cfg_t c);
        write_reg(REG_HEADER_TICKS, c.header_ticks);
        write_reg(REG_SPACE_TICKS, c.space_ticks);
        write_reg(REG_ONE_TICKS, c.one_ticks);
        write_reg(REG_GAP_TICKS, c.gap_ticks);
        write_reg(REG_BITS_FRAME, CFG_DATA_W'(c.bits_per_frame));
        write_reg(REG_FRAMES_CMD, CFG_DATA_W'(c.frames_per_command));
        write_reg(REG_SETTLE_TICKS, c.settle_ticks);
        cfg_wr_en = 1'b0;
        cfg = c;
    endtask

    // Mostly whole commands (start, ticks to done) with stray starts mixed in;
    // now and then a command is cut short so the next start lands while busy,
    // plus short bursts of random noise.
    task automatic play(input int n);
        int base;
        int k;
        int cut_at;
        logic cut;
        base = busy_items;
        while (busy_items - base < n) begin
            if ($urandom_range(99) < 85) begin
                send(FUNC_START, pick_code(), 1'b0, '0);
                cut    = ($urandom_range(9) == 0);
                cut_at = $urandom_range(1, 40);
                k      = 0;
                while (ph != P_IDLE && !(cut && k >= cut_at)) begin
                    if ($urandom_range(99) < 4)
                        send(FUNC_START, TX_CODE_W'($urandom), 1'b0, '0);
                    else
                        tick();
                    k++;
                end
            end else begin
                repeat ($urandom_range(1, 4))
                    send(1'($urandom_range(1)), TX_CODE_W'($urandom), 1'b0, '0);
            end
        end
    endtask

    task automatic run_phase(input cfg_t c, input int n);
        int keep_src;
        int keep_snk;
        keep_src = src_idle_pct;
        keep_snk = snk_idle_pct;
        load_regs(c);
        // some phases run flat out on both sides
        if ($urandom_range(3) == 0) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        play(n);
        run_to_idle();
        src_idle_pct = keep_src;
        snk_idle_pct = keep_snk;
        quiesce();
    endtask

    initial begin
        // predictor starts from the register defaults
        cfg = make_cfg(HEADER_TICKS_RST, SPACE_TICKS_RST, ONE_TICKS_RST, GAP_TICKS_RST,
                       BITS_FRAME_RST, FRAMES_CMD_RST, SETTLE_TICKS_RST);

        // Directed rows at the reset defaults. res_t is
        // {command_done, start_accepted, busy_res, carrier_on}.
        dir_rows[0] = {FUNC_TICK,  16'h0000, 4'b0000};  // tick while idle
        dir_rows[1] = {FUNC_TICK,  16'hFFFF, 4'b0000};  // code ignored on a tick
        dir_rows[2] = {FUNC_START, 16'hFFFF, 4'b0110};  // start taken, busy
        dir_rows[3] = {FUNC_START, 16'h0000, 4'b0010};  // start while busy dropped
        dir_rows[4] = {FUNC_TICK,  16'h0000, 4'b0011};  // header burst: carrier on
        dir_rows[5] = {FUNC_TICK,  16'hFFFF, 4'b0011};
        dir_rows[6] = {FUNC_START, 16'h5555, 4'b0010};
        dir_rows[7] = {FUNC_TICK,  16'hAAAA, 4'b0011};

        repeat (10) @(negedge aclk);
        aresetn = 1'b1;

        // sender idles lightly, receiver heavily
        src_idle_pct = 28;
        snk_idle_pct = 88;
        foreach (dir_rows[i])
            send(dir_rows[i].fn, dir_rows[i].code, 1'b1, dir_rows[i].want);
        row_typed = 1'b0;
        // shorten the rest of the default command: the header already loaded
        // runs out, later phases use one-tick durations
        quiesce();
        load_regs(make_cfg(1, 1, 1, 1, 1, 1, 0));
        run_to_idle();
        quiesce();

        // all zeros: one-tick durations, single bit and frame, no settle wait
        run_phase(make_cfg(0, 0, 0, 0, 0, 0, 0), 60);
        run_phase(make_cfg(1, 1, 1, 1, 1, 1, 1), 60);
        run_phase(rand_cfg(), 120);

        // roles swapped
        src_idle_pct = 88;
        snk_idle_pct = 28;
        // widest bit count (zeros past the code word)
        run_phase(make_cfg(1, 1, 1, 1, 31, 2, 0), 40);
        run_phase(rand_cfg(), 120);

        // no idling
        src_idle_pct = 0;
        snk_idle_pct = 0;
        // longer durations: one frame, one set bit
        load_regs(make_cfg(40, 2, 60, 50, 1, 1, 30));
        send(FUNC_START, 16'hFFFF, 1'b0, '0);
        run_to_idle();
        quiesce();
        // most frames
        run_phase(make_cfg(1, 1, 1, 1, 1, 15, 1), 40);
        run_phase(rand_cfg(), 100);

        // let any stray result surface before judging
        repeat (20) @(negedge aclk);
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
